// ----- hw/rtl/u2rs_pkg.sv -----
// Shared types and constants for the unsigned-to-radix-string converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package u2rs_pkg;

  localparam int DATA_W         = 64;
  localparam int CHAR_W         = 8;
  localparam int BASE_W         = 6;
  localparam int ALPHA_REGS     = 7;
  localparam int ALPHA_CHARS    = 56;
  localparam int CHAR_SLOTS     = 64;
  localparam int MAX_RADIX      = 56;
  localparam int MAX_DIGITS_DEF = 64;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FIRST = 3'd1;

  localparam logic [CHAR_W-1:0] SIGN_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SIGN_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ERR,
    S_DIV,
    S_FETCH,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/u2rs_alpha.sv -----
// Configuration registers, alphabet validity checker and digit-to-char lookup.
// Depends on u2rs_pkg.
`default_nettype none

module u2rs_alpha (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [u2rs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [u2rs_pkg::DATA_W-1:0]      cfg_data,
  input  wire logic                             chk_req,
  output u2rs_pkg::chk_stat_t                   chk,
  output logic      [u2rs_pkg::BASE_W-1:0]      base,
  input  wire logic [u2rs_pkg::BASE_W-1:0]      digit,
  output logic      [u2rs_pkg::CHAR_W-1:0]      digit_char
);
  import u2rs_pkg::*;

  logic [DATA_W-1:0] alpha_regs [ALPHA_REGS];
  logic [CHAR_W-1:0] chars [CHAR_SLOTS];
  logic [CHAR_SLOTS-1:0] match;
  logic [BASE_W-1:0] idx;
  logic [CHAR_W-1:0] cur_char;
  logic              cur_bad;
  logic              busy;
  logic              chk_done;
  logic              chk_ok;
  logic              base_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      for (int r = 0; r < ALPHA_REGS; r++) begin
        alpha_regs[r] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_LENGTH) begin
        base <= cfg_data[BASE_W-1:0];
      end else begin
        alpha_regs[cfg_index - REG_ALPHA_FIRST] <= cfg_data;
      end
    end
  end

  // slots past the seven registers read as zero
  for (genvar g = 0; g < CHAR_SLOTS; g++) begin : g_chars
    if (g < ALPHA_CHARS) begin : g_used
      assign chars[g] = alpha_regs[g / 8][(g % 8) * 8 +: 8];
    end else begin : g_zero
      assign chars[g] = '0;
    end
  end

  assign digit_char = chars[digit];

  // one alphabet position per cycle, compared against all lower positions
  assign cur_char = chars[idx];
  always_comb begin
    for (int j = 0; j < CHAR_SLOTS; j++) begin
      match[j] = (chars[j] == cur_char) && (BASE_W'(j) < idx);
    end
  end
  assign cur_bad  = (cur_char == SIGN_PLUS) || (cur_char == SIGN_MINUS) || (|match);
  assign base_bad = (base < BASE_W'(2)) || ({1'b0, base} > (BASE_W + 1)'(MAX_RADIX));

  // result is cached until the next register write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      busy     <= 1'b0;
      chk_done <= 1'b0;
      chk_ok   <= 1'b0;
    end else if (busy) begin
      if (cur_bad) begin
        busy     <= 1'b0;
        chk_done <= 1'b1;
        chk_ok   <= 1'b0;
      end else if (idx == base - BASE_W'(1)) begin
        busy     <= 1'b0;
        chk_done <= 1'b1;
        chk_ok   <= 1'b1;
      end else begin
        idx <= idx + BASE_W'(1);
      end
    end else if (chk_req && !chk_done) begin
      if (base_bad) begin
        chk_done <= 1'b1;
        chk_ok   <= 1'b0;
      end else begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end
  end

  assign chk.done = chk_done;
  assign chk.ok   = chk_ok;

endmodule

`default_nettype wire

// ----- hw/rtl/u2rs_divider.sv -----
// Shared divide unit: eight restoring long-division steps of one dividend
// byte by the radix per cycle. Depends on u2rs_pkg.
`default_nettype none

module u2rs_divider (
  input  wire logic [u2rs_pkg::BASE_W-1:0] base,
  input  wire logic [u2rs_pkg::BASE_W-1:0] rem_in,
  input  wire logic [u2rs_pkg::CHAR_W-1:0] byte_in,
  output logic      [u2rs_pkg::BASE_W-1:0] rem_out,
  output logic      [u2rs_pkg::CHAR_W-1:0] q_byte
);
  import u2rs_pkg::*;

  logic [BASE_W-1:0] r;
  logic [BASE_W:0]   t;

  always_comb begin
    r      = rem_in;
    q_byte = '0;
    t      = '0;
    for (int b = CHAR_W - 1; b >= 0; b--) begin
      t = {r, byte_in[b]};
      if (t >= {1'b0, base}) begin
        q_byte[b] = 1'b1;
        t         = t - {1'b0, base};
      end
      r = t[BASE_W-1:0];
    end
    rem_out = r;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/unsigned_to_radix_string.sv -----
// Top level: sequencer, digit memory and output register of the converter.
// Depends on u2rs_pkg, u2rs_alpha, u2rs_divider.
//
//  channel  | direction | word
//  s_axis   | in        | tdata[63:0] number_value
//  m_axis   | out       | tdata[7:0] out_char, tlast last_char, tuser bad_base
//  cfg      | in        | cfg_index selects register, cfg_data is the value
//
// Alphabet check: run on the first word after a register write and cached
// after that. Each digit is one pass of the shared divide unit over the
// significant bytes of the running quotient, one byte per cycle. Each
// character is a digit memory read (S_FETCH), then an output load (S_LOAD).
// Reset clears control state and registers; s_axis_tready is high only
// between conversions, and m_axis stalls hold the sequencer in its output
// load and error states.
`default_nettype none

module unsigned_to_radix_string #(
  parameter int MAX_DIGITS = u2rs_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [u2rs_pkg::DATA_W-1:0]    s_axis_tdata,   // [63:0] number_value
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [u2rs_pkg::CHAR_W-1:0]    m_axis_tdata,   // [7:0] out_char
  output logic                                m_axis_tlast,   // last_char
  output logic                                m_axis_tuser,   // [0] bad_base
  input  wire logic                           cfg_we,
  input  wire logic [u2rs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [u2rs_pkg::DATA_W-1:0]    cfg_data
);
  import u2rs_pkg::*;

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam logic [CW:0] MAXD = (CW + 1)'(MAX_DIGITS);

  state_t state, state_next;

  logic [DATA_W-1:0] wq;
  logic [DATA_W-1:0] quot_next;
  logic [BASE_W-1:0] rem;
  logic [2:0]        bp;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     pos;
  logic [BASE_W-1:0] mem [MAX_DIGITS];
  logic [BASE_W-1:0] rd_digit;

  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_bad;

  chk_stat_t         chk;
  logic [BASE_W-1:0] base;
  logic [CHAR_W-1:0] digit_char;
  logic [BASE_W-1:0] rem_out;
  logic [CHAR_W-1:0] q_byte;
  logic [CHAR_W-1:0] byte_in;

  logic accept;
  logic out_free;
  logic chk_req;
  logic load_err;
  logic load_chr;
  logic div_last;
  logic more_digits;

  function automatic logic [2:0] top_byte(input logic [DATA_W-1:0] v);
    logic [2:0] t;
    t = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (|v[b * 8 +: 8]) begin
        t = 3'(b);
      end
    end
    return t;
  endfunction

  u2rs_alpha u_alpha (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chk_req    (chk_req),
    .chk        (chk),
    .base       (base),
    .digit      (rd_digit),
    .digit_char (digit_char)
  );

  assign byte_in = wq[{bp, 3'b000} +: 8];

  u2rs_divider u_div (
    .base    (base),
    .rem_in  (rem),
    .byte_in (byte_in),
    .rem_out (rem_out),
    .q_byte  (q_byte)
  );

  always_comb begin
    quot_next                   = wq;
    quot_next[{bp, 3'b000} +: 8] = q_byte;
  end

  assign more_digits = (quot_next != '0) && (({1'b0, cnt} + (CW + 1)'(1)) < MAXD);
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_axis_tvalid) state_next = S_CHECK;
      S_CHECK: if (chk.done) state_next = chk.ok ? S_DIV : S_ERR;
      S_ERR:   if (out_free) state_next = S_IDLE;
      S_DIV:   if (bp == 3'd0 && !more_digits) state_next = S_FETCH;
      S_FETCH: state_next = S_LOAD;
      S_LOAD:  if (out_free) state_next = (pos == '0) ? S_IDLE : S_FETCH;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    chk_req       = (state == S_CHECK);
    load_err      = (state == S_ERR) && out_free;
    load_chr      = (state == S_LOAD) && out_free;
    div_last      = (state == S_DIV) && (bp == 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_err || load_chr) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wq  <= '0;
      cnt <= '0;
      bp  <= '0;
      rem <= '0;
      pos <= '0;
    end else begin
      if (accept) begin
        wq  <= s_axis_tdata;
        cnt <= '0;
      end
      if (state == S_CHECK) begin
        bp  <= top_byte(wq);
        rem <= '0;
      end
      if (state == S_DIV) begin
        wq <= quot_next;
        if (bp != 3'd0) begin
          rem <= rem_out;
          bp  <= bp - 3'd1;
        end else begin
          // digit done: next pass starts at the quotient's top byte
          cnt <= cnt + CW'(1);
          pos <= cnt[AW-1:0];
          rem <= '0;
          bp  <= top_byte(quot_next);
        end
      end
      if (load_chr && pos != '0) begin
        pos <= pos - AW'(1);
      end
    end
  end

  // digit memory, least significant digit at address 0
  always_ff @(posedge clk) begin
    if (div_last) begin
      mem[cnt[AW-1:0]] <= rem_out;
    end
    rd_digit <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      out_char <= '0;
      out_last <= 1'b1;
      out_bad  <= 1'b1;
    end else if (load_chr) begin
      out_char <= digit_char;
      out_last <= (pos == '0);
      out_bad  <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_char;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_bad;

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_CHECK)
    else $error("accepted word did not start a check");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < base)
    else $error("partial remainder not below radix");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_last && out_char == '0)
    else $error("error word malformed");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD && !out_free |=> state == S_LOAD && $stable(pos))
    else $error("character sequencer moved while output stalled");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH || state == S_LOAD) |-> {1'b0, pos} < (AW + 1)'(cnt))
    else $error("read pointer beyond digit count");

endmodule

`default_nettype wire

// ----- verif/unsigned_to_radix_string_tb.sv -----
// Self-checking bench for unsigned_to_radix_string: radix conversion of 64-bit words.
// Depends on u2rs_pkg and the RTL top; a scoreboard class predicts every output word.
`default_nettype none

module unsigned_to_radix_string_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2rs_pkg::*;

  localparam int MAX_DIGITS = MAX_DIGITS_DEF;
  localparam int ITEM_TARGET = 330;
  localparam int SETTLE = 16;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int IDLE_PCT = 21;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic tail;
    logic bad;
  } char_word_t;

  class radix_scoreboard;
    logic [BASE_W-1:0] radix_len;
    logic [DATA_W-1:0] alpha[ALPHA_REGS];
    char_word_t expected_q[$];
    int fails;
    int chars_checked;
    int error_words;

    function new();
      radix_len = '0;
      foreach (alpha[i]) alpha[i] = '0;
      fails = 0;
      chars_checked = 0;
      error_words = 0;
    endfunction

    function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      if (idx == REG_BASE_LENGTH) radix_len = val[BASE_W-1:0];
      else alpha[idx - REG_ALPHA_FIRST] = val;
    endfunction

    function logic [CHAR_W-1:0] glyph(int d);
      int r;
      r = d / 8;
      if (r >= ALPHA_REGS) return '0;
      return alpha[r][(d % 8) * CHAR_W +: CHAR_W];
    endfunction

    function bit alphabet_valid();
      logic [CHAR_W-1:0] c;
      if (radix_len < 2 || radix_len > MAX_RADIX) return 1'b0;
      for (int i = 0; i < radix_len; i++) begin
        c = glyph(i);
        if (c == SIGN_PLUS || c == SIGN_MINUS) return 1'b0;
        for (int j = 0; j < i; j++)
          if (glyph(j) == c) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Expected words per number: most significant digit first, or one error word.
    function void note_number(logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] q;
      logic [DATA_W-1:0] radix;
      int digits[MAX_DIGITS];
      int n;
      char_word_t w;
      if (!alphabet_valid()) begin
        w = '{ch: '0, tail: 1'b1, bad: 1'b1};
        expected_q.push_back(w);
        return;
      end
      radix = DATA_W'(radix_len);
      q = value;
      n = 0;
      do begin
        digits[n] = int'(q % radix);
        q = q / radix;
        n++;
      end while (q != 0 && n < MAX_DIGITS);
      for (int k = n - 1; k >= 0; k--) begin
        w = '{ch: glyph(digits[k]), tail: (k == 0), bad: 1'b0};
        expected_q.push_back(w);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic tail, logic bad);
      char_word_t w;
      if (expected_q.size() == 0) begin
        $error("unexpected output word: out_char %0h last_char %0b bad_base %0b",
               ch, tail, bad);
        fails++;
        return;
      end
      w = expected_q.pop_front();
      chars_checked++;
      if (bad) error_words++;
      if (ch !== w.ch) begin
        $error("out_char mismatch: expected %0h, actual %0h", w.ch, ch);
        fails++;
      end
      if (tail !== w.tail) begin
        $error("last_char mismatch: expected %0b, actual %0b", w.tail, tail);
        fails++;
      end
      if (bad !== w.bad) begin
        $error("bad_base mismatch: expected %0b, actual %0b", w.bad, bad);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [CHAR_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  radix_scoreboard sb;
  logic [CHAR_W-1:0] abc[ALPHA_CHARS];
  bit calm = 1'b0;
  int items_sent = 0;
  int phases = 0;
  int cycles = 0;

  unsigned_to_radix_string dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("unsigned_to_radix_string verification failed");
      $finish;
    end
  end

  // '0'-'9', 'a'-'z', 'A'-'T'
  function automatic void fill_ascii();
    for (int i = 0; i < ALPHA_CHARS; i++) begin
      if (i < 10) abc[i] = CHAR_W'(8'h30 + i);
      else if (i < 36) abc[i] = CHAR_W'(8'h61 + i - 10);
      else abc[i] = CHAR_W'(8'h41 + i - 36);
    end
  endfunction

  // Distinct random bytes, sign characters left out.
  function automatic void shuffle_alphabet();
    logic [CHAR_W-1:0] pool[$];
    logic [CHAR_W-1:0] t;
    int j;
    for (int b = 0; b < 256; b++)
      if (CHAR_W'(b) != SIGN_PLUS && CHAR_W'(b) != SIGN_MINUS) pool.push_back(CHAR_W'(b));
    for (int i = 0; i < ALPHA_CHARS; i++) begin
      j = $urandom_range(pool.size() - 1, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
      abc[i] = pool[i];
    end
  endfunction

  function automatic logic [DATA_W-1:0] alpha_word(int r);
    logic [DATA_W-1:0] v;
    for (int b = 0; b < 8; b++) v[b * CHAR_W +: CHAR_W] = abc[r * 8 + b];
    return v;
  endfunction

  // mask bit 0: base_length, bits 1..7: alphabet registers
  task automatic write_regs(input int base, input logic [7:0] mask);
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0] val;
    for (int r = 0; r < 8; r++) begin
      if (mask[r]) begin
        idx = (r == 0) ? REG_BASE_LENGTH : REG_ALPHA_FIRST + CFG_IDX_W'(r - 1);
        val = (r == 0) ? DATA_W'(base) : alpha_word(r - 1);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.note_reg(idx, val);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // tvalid stays up after the handshake so back-to-back words need no re-raise
  task automatic convert(input logic [DATA_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_number(value);
    items_sent++;
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    phases++;
  endtask

  function automatic logic [DATA_W-1:0] pick_number(int base);
    logic [DATA_W-1:0] p;
    int k;
    case ($urandom_range(9))
      0, 1, 2, 3: return {$urandom, $urandom};
      4, 5: return {$urandom, $urandom} >> $urandom_range(63);
      6: return DATA_W'($urandom_range(base * base));
      7: begin
        // near a power of the radix, where the digit count steps
        p = 1;
        k = $urandom_range(1, 40);
        while (k > 0 && p <= {DATA_W{1'b1}} / DATA_W'(base)) begin
          p = p * DATA_W'(base);
          k--;
        end
        return p - DATA_W'($urandom_range(1));
      end
      8: return {DATA_W{1'b1}};
      default: return DATA_W'($urandom_range(1));
    endcase
  endfunction

  initial begin
    int base;
    int n;
    int i;
    int j;
    logic [7:0] mask;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset alphabet has base 0: error word
    convert('0);
    finish_phase();

    fill_ascii();
    write_regs(10, 8'hFF);
    convert('0);
    convert(64'd1);
    convert(64'd9);
    convert(64'd10);
    convert({DATA_W{1'b1}});
    convert(64'd10000000000000000000);
    finish_phase();

    // binary: up to 64 digits
    write_regs(2, 8'h01);
    convert({DATA_W{1'b1}});
    convert('0);
    convert(64'd1);
    convert(64'h8000_0000_0000_0000);
    finish_phase();

    // full radix with a zero byte used as a digit character
    shuffle_alphabet();
    for (i = 0; i < ALPHA_CHARS; i++)
      if (abc[i] == 8'h00) abc[i] = abc[31];
    abc[31] = 8'h00;
    write_regs(MAX_RADIX, 8'hFF);
    convert({DATA_W{1'b1}});
    convert(64'd55);
    convert(64'd56);
    convert(64'd31 * 56 + 31);
    finish_phase();

    write_regs(1, 8'h01);
    convert(64'd7);
    finish_phase();
    write_regs(57, 8'h01);
    convert(64'd7);
    finish_phase();
    write_regs(63, 8'h01);
    convert(64'd7);
    finish_phase();

    fill_ascii();
    abc[15] = SIGN_PLUS;
    write_regs(16, 8'hFF);
    convert(64'hFEDC_BA98_7654_3210);
    finish_phase();
    // sign just past the used length is harmless
    fill_ascii();
    abc[16] = SIGN_PLUS;
    write_regs(16, 8'hFF);
    convert(64'hFEDC_BA98_7654_3210);
    finish_phase();
    fill_ascii();
    abc[0] = SIGN_MINUS;
    write_regs(16, 8'h02);
    convert(64'd255);
    finish_phase();
    fill_ascii();
    abc[12] = abc[3];
    write_regs(16, 8'h07);
    convert(64'd255);
    finish_phase();
    fill_ascii();
    abc[40] = abc[3];
    write_regs(16, 8'hFF);
    convert(64'hC0FF_EE00_1234_5678);
    finish_phase();

    while (items_sent < ITEM_TARGET) begin
      calm = (phases >= 24 && phases < 30);
      shuffle_alphabet();
      case ($urandom_range(9))
        0: base = 2;
        1: base = MAX_RADIX;
        default: base = $urandom_range(MAX_RADIX, 2);
      endcase
      n = $urandom_range(16, 6);
      if ($urandom_range(99) < 12) begin
        n = 3;
        case ($urandom_range(3))
          0: base = $urandom_range(1);
          1: base = $urandom_range(63, MAX_RADIX + 1);
          2: abc[$urandom_range(base - 1)] = $urandom_range(1) ? SIGN_PLUS : SIGN_MINUS;
          default: begin
            j = $urandom_range(base - 1, 1);
            i = $urandom_range(j - 1);
            abc[j] = abc[i];
          end
        endcase
      end
      mask = ($urandom_range(99) < 80) ? 8'hFF : 8'h01 | 8'($urandom_range(255));
      write_regs(base, mask);
      repeat (n) convert(pick_number(base < 2 ? 2 : base));
      finish_phase();
    end

    $display("Covered %0d numbers over %0d configuration phases.", items_sent, phases);
    $display("Checked %0d output words, %0d of them error flags.",
             sb.chars_checked, sb.error_words);
    if (sb.fails == 0)
      $display("unsigned_to_radix_string verification clean");
    else
      $display("unsigned_to_radix_string verification failed");
    $finish;
  end

endmodule

`default_nettype wire
